### hw/rtl/rle_pkg.sv
// Shared constants, types and codes of the ranked-list effectiveness block.
`default_nettype none
package rle_pkg;

  localparam int MAX_LIST   = 4096;
  localparam int CLASS_BITS = 8;
  localparam int FRAC_BITS  = 16;

  localparam int CLASS_W = 8;
  localparam int SIZE_W  = 16;
  localparam int CFG_W   = 13;
  localparam int POS_W   = 12;
  localparam int CNT_W   = 13;
  localparam int SUM_W   = 30;
  localparam int DEN_W   = 16;
  localparam int RES_W   = FRAC_BITS + 1;
  localparam int IN_W    = ((2 * CLASS_W + SIZE_W + 7) / 8) * 8;
  localparam int OUT_W   = ((3 * RES_W + 7) / 8) * 8;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  localparam logic [CFG_W-1:0] LIST_LEN_RST   = CFG_W'(16);
  localparam logic [CFG_W-1:0] PREC_CUT_RST   = CFG_W'(10);
  localparam logic [CFG_W-1:0] RECALL_CUT_RST = CFG_W'(10);

  typedef enum logic [1:0] {
    REG_LIST_LEN   = 2'd0,
    REG_PREC_CUT   = 2'd1,
    REG_RECALL_CUT = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ACC,
    BK_AP_GO,
    BK_AP,
    BK_PK,
    BK_RC,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    logic              acc;
    logic [CNT_W-1:0]  acc_num;
    logic [CNT_W-1:0]  acc_den;
    logic              fin;
    logic [SIZE_W-1:0] class_size;
    logic [DEN_W-1:0]  ap_den;
    logic [CNT_W-1:0]  kcut;
    logic [CNT_W-1:0]  hits_k;
    logic [CNT_W-1:0]  hits_r;
  } cmd_t;

endpackage
`default_nettype wire

### hw/rtl/rle_front.sv
// Front end: accepts list entries, tracks position and hit counts, issues commands.
`default_nettype none
module rle_front (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_tvalid,
  output logic                        in_tready,
  input  wire  [rle_pkg::IN_W-1:0]    in_tdata,
  input  wire  [rle_pkg::CFG_W-1:0]   list_len,
  input  wire  [rle_pkg::CFG_W-1:0]   prec_cut,
  input  wire  [rle_pkg::CFG_W-1:0]   recall_cut,
  input  wire                         q_full,
  output logic                        q_push,
  output rle_pkg::cmd_t               q_cmd
);
  import rle_pkg::*;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  hc_r, hc_nxt;
  logic [CNT_W-1:0]  hk_r, hk_nxt;
  logic [CNT_W-1:0]  hr_r, hr_nxt;

  logic [CLASS_W-1:0] qc, ic;
  logic [SIZE_W-1:0]  cs;
  logic [CFG_W-1:0]   len, kcut;
  logic [CNT_W-1:0]   pos_ext, pos_inc, hc_new, hk_new, hr_new;
  logic               hit, last, accept;

  always_comb begin
    qc = in_tdata[CLASS_W-1:0];
    ic = in_tdata[2*CLASS_W-1:CLASS_W];
    cs = in_tdata[2*CLASS_W+SIZE_W-1:2*CLASS_W];

    if (list_len == '0) begin
      len = CFG_W'(1);
    end else if (list_len > CFG_W'(MAX_LIST)) begin
      len = CFG_W'(MAX_LIST);
    end else begin
      len = list_len;
    end
    kcut = (prec_cut < len) ? prec_cut : len;

    hit     = (qc[CLASS_BITS-1:0] == ic[CLASS_BITS-1:0]);
    pos_ext = CNT_W'(pos_r);
    pos_inc = pos_ext + CNT_W'(1);
    last    = (pos_inc >= CNT_W'(len));
    hc_new  = hc_r + CNT_W'(hit);
    hk_new  = hk_r + CNT_W'(hit && (pos_ext < CNT_W'(kcut)));
    hr_new  = hr_r + CNT_W'(hit && (pos_ext < CNT_W'(recall_cut)));

    in_tready = !q_full;
    accept    = in_tvalid && !q_full;
    q_push    = accept && (hit || last);

    q_cmd.acc        = hit;
    q_cmd.acc_num    = hc_new;
    q_cmd.acc_den    = pos_inc;
    q_cmd.fin        = last;
    q_cmd.class_size = cs;
    q_cmd.ap_den     = (cs < SIZE_W'(len)) ? cs : DEN_W'(len);
    q_cmd.kcut       = CNT_W'(kcut);
    q_cmd.hits_k     = hk_new;
    q_cmd.hits_r     = hr_new;

    pos_nxt = pos_r;
    hc_nxt  = hc_r;
    hk_nxt  = hk_r;
    hr_nxt  = hr_r;
    if (accept) begin
      if (last) begin
        pos_nxt = '0;
        hc_nxt  = '0;
        hk_nxt  = '0;
        hr_nxt  = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        hc_nxt  = hc_new;
        hk_nxt  = hk_new;
        hr_nxt  = hr_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      hc_r  <= '0;
      hk_r  <= '0;
      hr_r  <= '0;
    end else begin
      pos_r <= pos_nxt;
      hc_r  <= hc_nxt;
      hk_r  <= hk_nxt;
      hr_r  <= hr_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/rle_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none
module rle_queue (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  rle_pkg::cmd_t  push_cmd,
  output logic           full,
  input  wire            pop,
  output rle_pkg::cmd_t  pop_cmd,
  output logic           empty
);
  import rle_pkg::*;

  cmd_t               entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]   fill_r, fill_nxt;
  logic               do_push, do_pop;

  always_comb begin
    full    = (fill_r == (Q_PTR_W+1)'(Q_DEPTH));
    empty   = (fill_r == '0);
    pop_cmd = entry_r[rd_ptr_r];
    do_push = push && !full;
    do_pop  = pop && !empty;

    wr_ptr_nxt = do_push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/rle_div.sv
// Radix-2 restoring divider giving a saturated unsigned fixed-point quotient.
`default_nettype none
module rle_div (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  input  wire  [rle_pkg::DEN_W-1:0]       hi,
  input  wire  [rle_pkg::FRAC_BITS-1:0]   lo,
  input  wire  [rle_pkg::DEN_W-1:0]       den,
  output logic                            done,
  output logic [rle_pkg::RES_W-1:0]       res
);
  import rle_pkg::*;

  localparam int STEP_W = $clog2(FRAC_BITS + 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [FRAC_BITS-1:0] lo_r, lo_nxt;
  logic [FRAC_BITS-1:0] quo_r, quo_nxt;
  logic [RES_W-1:0]     res_r, res_nxt;

  logic [DEN_W:0]       rem_sh, rem_diff;
  logic                 ge;

  // The dividend is hi * 2^FRAC_BITS + lo; when hi reaches den the quotient is at least 1.0.
  always_comb begin
    rem_sh   = {rem_r, lo_r[FRAC_BITS-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    ge       = (rem_sh >= {1'b0, den_r});

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    lo_nxt   = lo_r;
    quo_nxt  = quo_r;
    res_nxt  = res_r;

    if (start && !busy_r) begin
      if (den == '0) begin
        res_nxt  = '0;
        done_nxt = 1'b1;
      end else if (hi >= den) begin
        res_nxt  = {1'b1, {FRAC_BITS{1'b0}}};
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        step_nxt = STEP_W'(FRAC_BITS);
        rem_nxt  = hi;
        den_nxt  = den;
        lo_nxt   = lo;
        quo_nxt  = '0;
      end
    end else if (busy_r) begin
      rem_nxt  = ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      lo_nxt   = {lo_r[FRAC_BITS-2:0], 1'b0};
      quo_nxt  = {quo_r[FRAC_BITS-2:0], ge};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = {1'b0, quo_r[FRAC_BITS-2:0], ge};
      end
    end

    done = done_r;
    res  = res_r;
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    lo_r   <= lo_nxt;
    quo_r  <= quo_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/rle_back.sv
// Back end: accumulates running precision and computes the three list measures.
`default_nettype none
module rle_back (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         q_empty,
  input  rle_pkg::cmd_t               q_cmd,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  wire                         out_tready,
  output logic [rle_pkg::OUT_W-1:0]   out_tdata
);
  import rle_pkg::*;

  back_state_t          state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [RES_W-1:0]     ap_r, ap_nxt;
  logic [RES_W-1:0]     pk_r, pk_nxt;
  logic [RES_W-1:0]     rc_r, rc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_data_r, out_data_nxt;

  logic                 div_start, div_done;
  logic [DEN_W-1:0]     div_hi, div_den;
  logic [FRAC_BITS-1:0] div_lo;
  logic [RES_W-1:0]     div_res;

  rle_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .hi    (div_hi),
    .lo    (div_lo),
    .den   (div_den),
    .done  (div_done),
    .res   (div_res)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    sum_nxt       = sum_r;
    ap_nxt        = ap_r;
    pk_nxt        = pk_r;
    rc_nxt        = rc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    div_start     = 1'b0;
    div_hi        = '0;
    div_lo        = '0;
    div_den       = '0;

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          if (q_cmd.acc) begin
            div_start = 1'b1;
            div_hi    = DEN_W'(q_cmd.acc_num);
            div_den   = DEN_W'(q_cmd.acc_den);
            state_nxt = BK_ACC;
          end else begin
            state_nxt = BK_AP_GO;
          end
        end
      end
      BK_ACC: begin
        if (div_done) begin
          sum_nxt   = sum_r + SUM_W'(div_res);
          state_nxt = cmd_r.fin ? BK_AP_GO : BK_IDLE;
        end
      end
      BK_AP_GO: begin
        div_start = 1'b1;
        div_hi    = DEN_W'(sum_r[SUM_W-1:FRAC_BITS]);
        div_lo    = sum_r[FRAC_BITS-1:0];
        div_den   = cmd_r.ap_den;
        state_nxt = BK_AP;
      end
      BK_AP: begin
        if (div_done) begin
          ap_nxt    = div_res;
          div_start = 1'b1;
          div_hi    = DEN_W'(cmd_r.hits_k);
          div_den   = DEN_W'(cmd_r.kcut);
          state_nxt = BK_PK;
        end
      end
      BK_PK: begin
        if (div_done) begin
          pk_nxt    = div_res;
          div_start = 1'b1;
          div_hi    = DEN_W'(cmd_r.hits_r);
          div_den   = cmd_r.class_size;
          state_nxt = BK_RC;
        end
      end
      BK_RC: begin
        if (div_done) begin
          rc_nxt    = div_res;
          state_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({rc_r, pk_r, ap_r});
          sum_nxt       = '0;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    out_tvalid = out_valid_r;
    out_tdata  = out_data_r;
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    ap_r       <= ap_nxt;
    pk_r       <= pk_nxt;
    rc_r       <= rc_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ranked_list_effectiveness.sv
// Top level of the ranked-list effectiveness block: configuration and front/back wiring.
//
//   Channel  Direction  Contents (lowest bits first)
//   in_      request in   query_class[7:0], item_class[15:8], class_size[31:16]
//   out_     request out  avg_precision[16:0], precision_at_k[33:17], recall_at_cut[50:34]
//   cfg_     write only   index 0 list_len, 1 precision_cutoff, 2 recall_cutoff
//
// An entry that is neither a hit nor the end of a list is handled in the front end alone.
// Each hit costs the back end one pass of the shared radix-2 divider.
// A list end adds three divider passes, a start state and the result load.
// A four-entry command queue lets the front end run ahead while the divider is busy.
// Reset is synchronous and restores the configuration defaults 16, 10 and 10.
`default_nettype none
module ranked_list_effectiveness (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_tvalid,
  output logic                        in_tready,
  // query_class, item_class, class_size
  input  wire  [rle_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  wire                         out_tready,
  // avg_precision, precision_at_k, recall_at_cut, zero padding
  output logic [rle_pkg::OUT_W-1:0]   out_tdata,
  input  wire                         cfg_we,
  input  wire  [1:0]                  cfg_addr,
  input  wire  [rle_pkg::CFG_W-1:0]   cfg_wdata
);
  import rle_pkg::*;

  logic [CFG_W-1:0] list_len_r, list_len_nxt;
  logic [CFG_W-1:0] prec_cut_r, prec_cut_nxt;
  logic [CFG_W-1:0] recall_cut_r, recall_cut_nxt;

  logic q_full, q_empty, q_push, q_pop;
  cmd_t push_cmd, pop_cmd;

  always_comb begin
    list_len_nxt   = list_len_r;
    prec_cut_nxt   = prec_cut_r;
    recall_cut_nxt = recall_cut_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_LIST_LEN:   list_len_nxt   = cfg_wdata;
        REG_PREC_CUT:   prec_cut_nxt   = cfg_wdata;
        REG_RECALL_CUT: recall_cut_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_len_r   <= LIST_LEN_RST;
      prec_cut_r   <= PREC_CUT_RST;
      recall_cut_r <= RECALL_CUT_RST;
    end else begin
      list_len_r   <= list_len_nxt;
      prec_cut_r   <= prec_cut_nxt;
      recall_cut_r <= recall_cut_nxt;
    end
  end

  rle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .list_len   (list_len_r),
    .prec_cut   (prec_cut_r),
    .recall_cut (recall_cut_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  rle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  rle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the ranked-list effectiveness block.
`timescale 1ns / 100ps

module tb_top;
  import rle_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int HOLD_CYCLES    = 400;
  localparam int BURST_ENTRIES  = 54;
  localparam int LONG_ENTRIES   = 100;

  typedef struct packed {
    logic [RES_W-1:0] recall_at_cut;
    logic [RES_W-1:0] precision_at_k;
    logic [RES_W-1:0] avg_precision;
  } list_scores_t;

  class ranked_list_checker;
    logic [CFG_W-1:0] list_len_reg;
    logic [CFG_W-1:0] prec_cut_reg;
    logic [CFG_W-1:0] recall_cut_reg;
    longint unsigned  position;
    longint unsigned  hit_count;
    longint unsigned  hits_k;
    longint unsigned  hits_r;
    longint unsigned  prec_sum;
    list_scores_t     pending_scores[$];
    int               mismatches;
    int               entries_seen;
    int               lists_checked;
    int               hits_seen;

    function new();
      list_len_reg   = LIST_LEN_RST;
      prec_cut_reg   = PREC_CUT_RST;
      recall_cut_reg = RECALL_CUT_RST;
      clear_list();
    endfunction

    function void clear_list();
      position  = 0;
      hit_count = 0;
      hits_k    = 0;
      hits_r    = 0;
      prec_sum  = 0;
    endfunction

    function longint unsigned ratio_q(longint unsigned num, longint unsigned den);
      longint unsigned q;
      q = (num << FRAC_BITS) / den;
      return (q > (64'd1 << FRAC_BITS)) ? (64'd1 << FRAC_BITS) : q;
    endfunction

    function void set_register(reg_idx_t idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_LIST_LEN:   list_len_reg = value;
        REG_PREC_CUT:   prec_cut_reg = value;
        REG_RECALL_CUT: recall_cut_reg = value;
        default: ;
      endcase
    endfunction

    // Updates the running list state and queues the scores when the entry closes a list.
    function void note_entry(logic [CLASS_W-1:0] qc, logic [CLASS_W-1:0] ic,
                             logic [SIZE_W-1:0] cs);
      longint unsigned len;
      longint unsigned kcut;
      longint unsigned den;
      longint unsigned q;
      list_scores_t    scores;
      entries_seen++;
      len  = (list_len_reg == 0) ? 1 : ((list_len_reg > MAX_LIST) ? MAX_LIST : list_len_reg);
      kcut = (prec_cut_reg < len) ? prec_cut_reg : len;
      if (qc == ic) begin
        hits_seen++;
        hit_count++;
        prec_sum += ratio_q(hit_count, position + 1);
        if (position < kcut) hits_k++;
        if (position < recall_cut_reg) hits_r++;
      end
      if (position + 1 < len) begin
        position++;
        return;
      end
      if (cs == 0) begin
        scores.avg_precision = '0;
        scores.recall_at_cut = '0;
      end else begin
        den = (cs < len) ? cs : len;
        q   = prec_sum / den;
        scores.avg_precision = RES_W'((q > (64'd1 << FRAC_BITS)) ? (64'd1 << FRAC_BITS) : q);
        scores.recall_at_cut = RES_W'(ratio_q(hits_r, cs));
      end
      scores.precision_at_k = (kcut == 0) ? '0 : RES_W'(ratio_q(hits_k, kcut));
      pending_scores.push_back(scores);
      clear_list();
    endfunction

    function void check_scores(list_scores_t got);
      list_scores_t want;
      if (pending_scores.size() == 0) begin
        $error("Unexpected result: ap %0d, pk %0d, rc %0d.", got.avg_precision,
               got.precision_at_k, got.recall_at_cut);
        mismatches++;
        return;
      end
      want = pending_scores.pop_front();
      lists_checked++;
      if (got.avg_precision !== want.avg_precision) begin
        $error("avg_precision: expected %0d, actual %0d", want.avg_precision,
               got.avg_precision);
        mismatches++;
      end
      if (got.precision_at_k !== want.precision_at_k) begin
        $error("precision_at_k: expected %0d, actual %0d", want.precision_at_k,
               got.precision_at_k);
        mismatches++;
      end
      if (got.recall_at_cut !== want.recall_at_cut) begin
        $error("recall_at_cut: expected %0d, actual %0d", want.recall_at_cut,
               got.recall_at_cut);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_addr = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  ranked_list_checker sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  ranked_list_effectiveness DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_scores(out_tdata[3*RES_W-1:0]);
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_entry(logic [CLASS_W-1:0] qc, logic [CLASS_W-1:0] ic,
                            logic [SIZE_W-1:0] cs);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {cs, ic, qc};
    do @(posedge clk); while (!in_tready);
    sb.note_entry(qc, ic, cs);
  endtask

  task automatic drain_scores();
    in_tvalid <= 1'b0;
    while (sb.pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    sb.set_register(idx, CFG_W'(value));
  endtask

  task automatic configure(int len, int pcut, int rcut);
    write_reg(REG_LIST_LEN, len);
    write_reg(REG_PREC_CUT, pcut);
    write_reg(REG_RECALL_CUT, rcut);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SIZE_W-1:0] pick_class_size(int eff);
    case ($urandom_range(9))
      0:             return '0;
      1, 2, 3, 4, 5: return SIZE_W'($urandom_range(1, eff + 3));
      default:       return SIZE_W'($urandom);
    endcase
  endfunction

  function automatic int pick_cutoff(int eff);
    case ($urandom_range(4))
      0:       return 0;
      1:       return eff;
      2:       return $urandom_range(1, eff);
      3:       return $urandom_range(eff, eff + 5);
      default: return $urandom_range(0, 8191);
    endcase
  endfunction

  // A tidy list keeps one query class and size; otherwise every entry is scrambled.
  task automatic send_list(int eff, bit tidy, int hit_pct);
    logic [CLASS_W-1:0] qc;
    logic [CLASS_W-1:0] ic;
    logic [SIZE_W-1:0]  cs;
    qc = CLASS_W'($urandom);
    cs = pick_class_size(eff);
    for (int i = 0; i < eff; i++) begin
      if (!tidy) begin
        qc = CLASS_W'($urandom);
        cs = pick_class_size(eff);
      end
      ic = ($urandom_range(99) < hit_pct) ? qc : CLASS_W'($urandom);
      send_entry(qc, ic, cs);
    end
  endtask

  initial begin
    int len_reg;
    int eff;
    int sent;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short lists with full hits, misses, zero and tiny class sizes, extreme ids.
    configure(4, 2, 3);
    for (int i = 0; i < 4; i++) send_entry(8'd255, 8'd255, (i == 3) ? 16'd1 : 16'hFFFF);
    send_entry(8'd0, 8'd1, 16'd0);
    send_entry(8'd0, 8'd0, 16'd0);
    send_entry(8'd1, 8'd0, 16'd0);
    send_entry(8'd0, 8'd0, 16'd0);
    for (int i = 0; i < 4; i++) send_entry(8'd170, 8'd85, 16'hFFFF);
    send_entry(8'd85, 8'd85, 16'd7);
    send_entry(8'd85, 8'd170, 16'd7);
    send_entry(8'd85, 8'd170, 16'd7);
    send_entry(8'd85, 8'd85, 16'd2);
    drain_scores();
    // Zero list length acts as one; zero cutoffs give zero precision and recall scores.
    configure(0, 0, 0);
    send_entry(8'd37, 8'd37, 16'd5);
    send_entry(8'd200, 8'd201, 16'd0);
    drain_scores();
    // A list cut short by lowering the length while it is partly received.
    configure(16, 16, 16);
    send_entry(8'd12, 8'd12, 16'd3);
    send_entry(8'd12, 8'd13, 16'd3);
    send_entry(8'd12, 8'd12, 16'd3);
    send_entry(8'd12, 8'd12, 16'd3);
    send_entry(8'd12, 8'd99, 16'd3);
    drain_scores();
    configure(3, 8191, 8191);
    send_entry(8'd12, 8'd12, 16'd3);

    for (int mode = 0; mode < 4; mode++) begin
      for (int burst = 0; burst < 4; burst++) begin
        drain_scores();
        case (mode)
          0: begin idle_pct = 0;  stall_pct <= 0;  end
          1: begin idle_pct = 52; stall_pct <= 0;  end
          2: begin idle_pct = 0;  stall_pct <= 52; end
          default: begin idle_pct = 11; stall_pct <= 11; end
        endcase
        case ($urandom_range(9))
          0:       len_reg = 0;
          1:       len_reg = 1;
          2:       len_reg = 2;
          8, 9:    len_reg = $urandom_range(11, 24);
          default: len_reg = $urandom_range(3, 10);
        endcase
        eff = (len_reg == 0) ? 1 : len_reg;
        configure(len_reg, pick_cutoff(eff), pick_cutoff(eff));
        if (mode == 0 && burst == 0) hold_requests <= hold_requests + 1;
        sent = 0;
        while (sent < BURST_ENTRIES) begin
          send_list(eff, $urandom_range(99) < 85, $urandom_range(100));
          sent += eff;
        end
      end
    end

    // Largest lengths, written directly and through saturation; each list is closed
    // early by lowering the length.
    drain_scores();
    idle_pct = 0;
    stall_pct <= 0;
    configure(MAX_LIST, MAX_LIST, MAX_LIST);
    send_list(LONG_ENTRIES, 1'b1, 20);
    drain_scores();
    configure(LONG_ENTRIES / 2, MAX_LIST, MAX_LIST);
    send_entry(8'd9, 8'd9, 16'd40);
    drain_scores();
    configure(8191, 8191, 1);
    send_list(LONG_ENTRIES, 1'b1, 10);
    drain_scores();
    configure(1, 8191, 1);
    send_entry(8'd77, 8'd78, 16'd500);
    drain_scores();

    $display("Checked %0d ranked lists built from %0d entries with %0d hits; %0d mismatches.",
             sb.lists_checked, sb.entries_seen, sb.hits_seen, sb.mismatches);
    $display("Lengths 1 to the maximum, cutoffs 0 to 8191, zero and small class sizes, %s",
             "four idle mixes and a long output hold.");
    if (sb.mismatches == 0 && sb.pending_scores.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
